// File: sv/anxb_pkg.sv
// Shared types and constants for the Annex-B access unit splitter.
// No dependencies; used by annexb_nal_access_unit_splitter.
package anxb_pkg;

    localparam int OFFSET_BITS_DEF   = 48;
    localparam int MAX_PSET_LEN_DEF  = 256;
    localparam int OUT_OFF_W         = 48;
    localparam int DUR_W             = 20;
    localparam int FC_W              = 48;
    localparam int HALF_FC_W         = 24;
    localparam int AU_LEN_W          = 24;

    localparam logic [DUR_W-1:0]    DUR_RESET   = 20'd33333;
    localparam logic [AU_LEN_W-1:0] AU_LEN_MAX  = 24'hFF_FFFF;

    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
    localparam logic [4:0] NAL_TYPE_AUD = 5'd9;

    localparam logic [2:0] SC_LEN_NONE = 3'd0;
    localparam logic [2:0] SC_LEN_3    = 3'd3;
    localparam logic [2:0] SC_LEN_4    = 3'd4;

    typedef enum logic [0:0] {
        EV_NAL_HDR = 1'b0,
        EV_AU_DONE = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        t_event_kind              event_kind;
        logic [4:0]               nal_type;
        logic [OUT_OFF_W-1:0]     start_offset;
        logic [2:0]               start_code_len;
        logic [AU_LEN_W-1:0]      au_length;
        logic                     au_is_sync;
        logic                     params_ready;
        logic [OUT_OFF_W-1:0]     pts_us;
        logic [7:0]               profile_byte;
        logic [7:0]               compat_byte;
        logic [7:0]               level_byte;
        logic                     last_of_run;
    } t_out_word;

    // parameter set capture status
    typedef struct packed {
        logic        sps_cap;
        logic        sps_ge4;
        logic        pps_cap;
        logic [23:0] sps_prof;
    } t_cap;

endpackage

// File: sv/annexb_nal_access_unit_splitter.sv
// Annex-B start code parser and access unit splitter, top level; depends on anxb_pkg.
// Flow: a byte is registered, then processed into a 4-word result queue that drives
//   the output. Throughput: 1 byte per cycle while each byte yields at most one word,
//   the output takes each word and no duration write is pending; a byte yielding more
//   words holds off input until the queue drains, and a duration write holds it off too.
// Reset (i_rst_n, sync, low) clears parser state and sets frame duration to 33333 us.
module annexb_nal_access_unit_splitter #(
    parameter int OFFSET_BITS       = anxb_pkg::OFFSET_BITS_DEF,
    parameter int MAX_PARAM_SET_LEN = anxb_pkg::MAX_PSET_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // byte input
    input  logic                         i_valid,
    output logic                         o_ready,
    input  anxb_pkg::t_in_word           i_data,
    // result output
    output logic                         o_valid,
    input  logic                         i_ready,
    output anxb_pkg::t_out_word          o_data,
    // frame duration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [anxb_pkg::DUR_W-1:0]   i_cfg_data
);

    localparam int OB = OFFSET_BITS;
    localparam int HW = anxb_pkg::HALF_FC_W;

    // ---------------- input register ----------------
    logic               r_in_valid;
    anxb_pkg::t_in_word r_in;

    // ---------------- parser state ----------------
    logic [1:0]    r_zero_run,  n_zero_run;
    logic [OB-1:0] r_offset;
    logic          r_expect,    n_expect;
    logic [OB-1:0] r_pending,   n_pending;
    logic [4:0]    r_nal_type,  n_nal_type;
    logic [OB-1:0] r_hdr_pos,   n_hdr_pos;
    logic [7:0]    r_nb0, r_nb1, r_nb2;
    logic [7:0]    n_nb0, n_nb1, n_nb2;
    logic          r_in_au,     n_in_au;
    logic [OB-1:0] r_au_start,  n_au_start;
    logic          r_au_idr,    n_au_idr;
    anxb_pkg::t_cap r_cap,      n_cap;
    logic          r_rdy,       n_rdy;
    logic [anxb_pkg::FC_W-1:0]      r_fc,  n_fc;
    logic [anxb_pkg::OUT_OFF_W-1:0] r_pts, n_pts;
    logic [anxb_pkg::DUR_W-1:0]     r_dur;

    // time product rebuild after a duration write
    logic                                  r_mul_a, r_mul_b;
    logic [HW+anxb_pkg::DUR_W-1:0]         r_plo;
    logic [HW-1:0]                         r_phi;
    logic                                  mul_busy;

    // ---------------- result queue ----------------
    anxb_pkg::t_out_word r_q [4];
    logic [1:0]          r_head, r_tail;
    logic [2:0]          r_cnt;
    logic                pop;
    logic                do_proc;

    anxb_pkg::t_out_word v_res [3];
    logic [1:0]          v_nres;
    logic [OB-1:0]       v_pos, v_end, v_d;
    logic [4:0]          v_type;

    // Close the open NAL: capture first SPS / PPS that fit the length limit.
    function automatic anxb_pkg::t_cap close_nal(
        input anxb_pkg::t_cap cap,
        input logic [OB-1:0]  len,
        input logic [4:0]     ntype,
        input logic [7:0]     b0,
        input logic [7:0]     b1,
        input logic [7:0]     b2
    );
        anxb_pkg::t_cap c;
        logic [23:0]    prof;
        c    = cap;
        prof = {(len > OB'(1)) ? b0 : 8'h00,
                (len > OB'(2)) ? b1 : 8'h00,
                (len > OB'(3)) ? b2 : 8'h00};
        if (len != '0 && len <= OB'(MAX_PARAM_SET_LEN)) begin
            if (ntype == anxb_pkg::NAL_TYPE_SPS && !c.sps_cap) begin
                c.sps_cap  = 1'b1;
                c.sps_ge4  = (len >= OB'(4));
                c.sps_prof = prof;
            end
            if (ntype == anxb_pkg::NAL_TYPE_PPS && !c.pps_cap) begin
                c.pps_cap = 1'b1;
            end
        end
        return c;
    endfunction

    // Build an access unit word; length saturates at 24 bits.
    function automatic anxb_pkg::t_out_word au_word(
        input logic [23:0]                    prof,
        input logic [OB-1:0]                  start_pos,
        input logic [OB-1:0]                  stop_pos,
        input logic                           idr,
        input logic                           rdy,
        input logic [anxb_pkg::OUT_OFF_W-1:0] pts
    );
        anxb_pkg::t_out_word w;
        logic [OB-1:0]       diff;
        diff                   = stop_pos - start_pos;
        w                      = '0;
        w.event_kind           = anxb_pkg::EV_AU_DONE;
        w.start_offset         = anxb_pkg::OUT_OFF_W'(start_pos);
        w.start_code_len       = anxb_pkg::SC_LEN_NONE;
        w.au_length            = (diff > OB'(anxb_pkg::AU_LEN_MAX)) ?
                                 anxb_pkg::AU_LEN_MAX : anxb_pkg::AU_LEN_W'(diff);
        w.au_is_sync           = idr;
        w.params_ready         = rdy;
        w.pts_us               = pts;
        w.profile_byte         = prof[23:16];
        w.compat_byte          = prof[15:8];
        w.level_byte           = prof[7:0];
        return w;
    endfunction

    // ---------------- handshakes ----------------
    assign mul_busy    = r_mul_a | r_mul_b;
    // room for up to three words without looking at the output side
    assign do_proc     = r_in_valid && !mul_busy && (r_cnt <= 3'd1);
    assign o_ready     = !r_in_valid || do_proc;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_cnt != 3'd0);
    assign o_data      = r_q[r_head];
    assign pop         = o_valid && i_ready;

    // ---------------- per-byte parse step ----------------
    always_comb begin
        n_zero_run = r_zero_run;
        n_expect   = r_expect;
        n_pending  = r_pending;
        n_nal_type = r_nal_type;
        n_hdr_pos  = r_hdr_pos;
        n_nb0      = r_nb0;
        n_nb1      = r_nb1;
        n_nb2      = r_nb2;
        n_in_au    = r_in_au;
        n_au_start = r_au_start;
        n_au_idr   = r_au_idr;
        n_cap      = r_cap;
        n_rdy      = r_rdy;
        n_fc       = r_fc;
        n_pts      = r_pts;
        v_res[0]   = '0;
        v_res[1]   = '0;
        v_res[2]   = '0;
        v_nres     = 2'd0;
        v_pos      = r_offset;
        v_end      = r_offset + OB'(1);
        v_type     = r_in.data_byte[4:0];
        v_d        = r_offset - r_hdr_pos;

        if (r_expect) begin
            // this byte is a NAL header; never part of a zero run
            n_expect = 1'b0;
            if (r_in_au) begin
                n_cap = close_nal(n_cap, r_pending - r_hdr_pos, r_nal_type,
                                  r_nb0, r_nb1, r_nb2);
                if (v_type == anxb_pkg::NAL_TYPE_AUD) begin
                    // delimiter closes the running access unit first
                    n_rdy         = n_rdy | (n_cap.sps_ge4 & n_cap.pps_cap);
                    v_res[v_nres] = au_word(n_cap.sps_prof, r_au_start, r_pending,
                                            r_au_idr, n_rdy, n_pts);
                    v_nres        = v_nres + 2'd1;
                    n_pts         = n_pts + anxb_pkg::OUT_OFF_W'(r_dur);
                    n_fc          = n_fc + anxb_pkg::FC_W'(1);
                end
            end
            if (v_type == anxb_pkg::NAL_TYPE_AUD) begin
                n_in_au    = 1'b1;
                n_au_start = r_pending;
                n_au_idr   = 1'b0;
            end
            if (n_in_au && v_type == anxb_pkg::NAL_TYPE_IDR) begin
                n_au_idr = 1'b1;
            end
            n_nal_type = v_type;
            n_hdr_pos  = v_pos;
            n_nb0      = 8'h00;
            n_nb1      = 8'h00;
            n_nb2      = 8'h00;
            v_res[v_nres].event_kind     = anxb_pkg::EV_NAL_HDR;
            v_res[v_nres].nal_type       = v_type;
            v_res[v_nres].start_offset   = anxb_pkg::OUT_OFF_W'(r_pending);
            v_res[v_nres].start_code_len = ((v_pos - r_pending) == OB'(4)) ?
                                           anxb_pkg::SC_LEN_4 : anxb_pkg::SC_LEN_3;
            v_nres     = v_nres + 2'd1;
            n_zero_run = 2'd0;
        end else begin
            // keep the first three payload bytes of the open NAL
            if (v_d == OB'(1)) n_nb0 = r_in.data_byte;
            if (v_d == OB'(2)) n_nb1 = r_in.data_byte;
            if (v_d == OB'(3)) n_nb2 = r_in.data_byte;
            if (r_in.data_byte == 8'h00) begin
                if (r_zero_run != 2'd3) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else if (r_in.data_byte == 8'h01 && r_zero_run >= 2'd2) begin
                // three or more zeros make a 4-byte code
                n_pending  = v_pos - ((r_zero_run == 2'd3) ? OB'(3) : OB'(2));
                n_expect   = 1'b1;
                n_zero_run = 2'd0;
            end else begin
                n_zero_run = 2'd0;
            end
        end

        if (r_in.end_of_stream) begin
            if (n_in_au) begin
                n_cap = close_nal(n_cap, (n_expect ? n_pending : v_end) - n_hdr_pos,
                                  n_nal_type, n_nb0, n_nb1, n_nb2);
                n_rdy         = n_rdy | (n_cap.sps_ge4 & n_cap.pps_cap);
                v_res[v_nres] = au_word(n_cap.sps_prof, n_au_start, v_end,
                                        n_au_idr, n_rdy, n_pts);
                v_nres        = v_nres + 2'd1;
                n_pts         = n_pts + anxb_pkg::OUT_OFF_W'(r_dur);
                n_fc          = n_fc + anxb_pkg::FC_W'(1);
            end
            // parsing restarts; offsets and captures are kept
            n_in_au    = 1'b0;
            n_expect   = 1'b0;
            n_zero_run = 2'd0;
            n_au_idr   = 1'b0;
        end

        if (v_nres != 2'd0) begin
            v_res[v_nres - 2'd1].last_of_run = 1'b1;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // ---------------- parser state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_offset   <= '0;
            r_expect   <= 1'b0;
            r_pending  <= '0;
            r_nal_type <= 5'd0;
            r_hdr_pos  <= '0;
            r_nb0      <= 8'h00;
            r_nb1      <= 8'h00;
            r_nb2      <= 8'h00;
            r_in_au    <= 1'b0;
            r_au_start <= '0;
            r_au_idr   <= 1'b0;
            r_cap      <= '0;
            r_rdy      <= 1'b0;
            r_fc       <= '0;
            r_pts      <= '0;
        end else begin
            if (do_proc) begin
                r_zero_run <= n_zero_run;
                r_offset   <= v_end;
                r_expect   <= n_expect;
                r_pending  <= n_pending;
                r_nal_type <= n_nal_type;
                r_hdr_pos  <= n_hdr_pos;
                r_nb0      <= n_nb0;
                r_nb1      <= n_nb1;
                r_nb2      <= n_nb2;
                r_in_au    <= n_in_au;
                r_au_start <= n_au_start;
                r_au_idr   <= n_au_idr;
                r_cap      <= n_cap;
                r_rdy      <= n_rdy;
                r_fc       <= n_fc;
                r_pts      <= n_pts;
            end else if (r_mul_b) begin
                // pts = frame_count * duration, mod 2^48
                r_pts <= anxb_pkg::OUT_OFF_W'(r_plo) + {r_phi, {HW{1'b0}}};
            end
        end
    end

    // ---------------- duration register and product rebuild ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur   <= anxb_pkg::DUR_RESET;
            r_mul_a <= 1'b0;
            r_mul_b <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dur   <= i_cfg_data;
            r_mul_a <= 1'b1;
            r_mul_b <= 1'b0;
        end else begin
            r_mul_a <= 1'b0;
            r_mul_b <= r_mul_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mul_a) begin
            r_plo <= r_fc[HW-1:0] * r_dur;
            r_phi <= HW'(r_fc[2*HW-1:HW] * r_dur);
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 2'd0;
            r_tail <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_head <= r_head + {1'b0, pop};
            r_tail <= r_tail + (do_proc ? v_nres : 2'd0);
            r_cnt  <= r_cnt + (do_proc ? 3'(v_nres) : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (do_proc && 2'(k) < v_nres) begin
                r_q[r_tail + 2'(k)] <= v_res[k];
            end
        end
    end

endmodule
